[rtl/irclt_pkg.sv]
package irclt_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [3:0] {
        MODE_LINE_START   = 4'd0,
        MODE_PREFIX_FIRST = 4'd1,
        MODE_PREFIX       = 4'd2,
        MODE_PRE_CMD      = 4'd3,
        MODE_CMD          = 4'd4,
        MODE_PRE_PARAM    = 4'd5,
        MODE_MIDDLE       = 4'd6,
        MODE_TRAIL_FIRST  = 4'd7,
        MODE_TRAIL        = 4'd8,
        MODE_BAD          = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        KIND_PREFIX  = 3'd0,
        KIND_COMMAND = 3'd1,
        KIND_MIDDLE  = 3'd2,
        KIND_TRAIL   = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       has_byte;
        logic       start;
        logic       malformed;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } cand_t;

endpackage

[rtl/irc_line_tokenizer.sv]
// A byte's results are written into a result queue when the byte is accepted, and
// the m_ side presents the queue head. Throughput: one input byte per cycle while
// s_tready is high; a byte that yields two results gives two separate transfers,
// and a four-entry result queue lets input continue while results wait. Reset clears
// the parse mode, the held CR flag and the queue pointers; queue contents are not cleared.
module irc_line_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] token_byte
    output logic [5:0] m_tuser,   // [2:0] token_kind, [3] has_byte, [4] token_start, [5] malformed
    output logic       m_tlast    // step_last
);

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef irclt_pkg::result_t result_t;
    typedef irclt_pkg::cand_t cand_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic result_t mk(input irclt_pkg::kind_t kind, input logic [7:0] data,
                                   input logic has, input logic start, input logic mal);
        result_t r;
        r.kind      = kind;
        r.data      = data;
        r.has_byte  = has;
        r.start     = start;
        r.malformed = mal;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic irclt_pkg::mode_t byte_next(input irclt_pkg::mode_t mode,
                                                   input logic [7:0] c);
        irclt_pkg::mode_t m;
        m = mode;
        unique case (mode)
            irclt_pkg::MODE_PREFIX_FIRST:
                m = (c == irclt_pkg::CH_SPACE) ? irclt_pkg::MODE_BAD : irclt_pkg::MODE_PREFIX;
            irclt_pkg::MODE_PREFIX:
                if (c == irclt_pkg::CH_SPACE) m = irclt_pkg::MODE_PRE_CMD;
            irclt_pkg::MODE_PRE_CMD:
                if (c != irclt_pkg::CH_SPACE) m = irclt_pkg::MODE_CMD;
            irclt_pkg::MODE_CMD:
                if (c == irclt_pkg::CH_SPACE) m = irclt_pkg::MODE_PRE_PARAM;
            irclt_pkg::MODE_PRE_PARAM: begin
                if (c == irclt_pkg::CH_COLON) m = irclt_pkg::MODE_TRAIL_FIRST;
                else if (c != irclt_pkg::CH_SPACE) m = irclt_pkg::MODE_MIDDLE;
            end
            irclt_pkg::MODE_MIDDLE:
                if (c == irclt_pkg::CH_SPACE) m = irclt_pkg::MODE_PRE_PARAM;
            irclt_pkg::MODE_TRAIL_FIRST: m = irclt_pkg::MODE_TRAIL;
            irclt_pkg::MODE_TRAIL:       m = irclt_pkg::MODE_TRAIL;
            irclt_pkg::MODE_BAD:         m = irclt_pkg::MODE_BAD;
            default: begin
                if (c == irclt_pkg::CH_COLON) m = irclt_pkg::MODE_PREFIX_FIRST;
                else if (c == irclt_pkg::CH_SPACE) m = irclt_pkg::MODE_PRE_CMD;
                else m = irclt_pkg::MODE_CMD;
            end
        endcase
        return m;
    endfunction

    function automatic cand_t byte_out(input irclt_pkg::mode_t mode, input logic [7:0] c);
        cand_t o;
        o.valid = 1'b0;
        o.res   = mk(irclt_pkg::KIND_COMMAND, upcase(c), 1'b1, 1'b0, 1'b0);
        unique case (mode)
            irclt_pkg::MODE_PREFIX_FIRST: begin
                o.valid = (c != irclt_pkg::CH_SPACE);
                o.res   = mk(irclt_pkg::KIND_PREFIX, c, 1'b1, 1'b1, 1'b0);
            end
            irclt_pkg::MODE_PREFIX: begin
                o.valid = (c != irclt_pkg::CH_SPACE);
                o.res   = mk(irclt_pkg::KIND_PREFIX, c, 1'b1, 1'b0, 1'b0);
            end
            irclt_pkg::MODE_PRE_CMD: begin
                o.valid = (c != irclt_pkg::CH_SPACE);
                o.res   = mk(irclt_pkg::KIND_COMMAND, upcase(c), 1'b1, 1'b1, 1'b0);
            end
            irclt_pkg::MODE_CMD: begin
                o.valid = (c != irclt_pkg::CH_SPACE);
            end
            irclt_pkg::MODE_PRE_PARAM: begin
                o.valid = (c != irclt_pkg::CH_SPACE) && (c != irclt_pkg::CH_COLON);
                o.res   = mk(irclt_pkg::KIND_MIDDLE, c, 1'b1, 1'b1, 1'b0);
            end
            irclt_pkg::MODE_MIDDLE: begin
                o.valid = (c != irclt_pkg::CH_SPACE);
                o.res   = mk(irclt_pkg::KIND_MIDDLE, c, 1'b1, 1'b0, 1'b0);
            end
            irclt_pkg::MODE_TRAIL_FIRST: begin
                o.valid = 1'b1;
                o.res   = mk(irclt_pkg::KIND_TRAIL, c, 1'b1, 1'b1, 1'b0);
            end
            irclt_pkg::MODE_TRAIL: begin
                o.valid = 1'b1;
                o.res   = mk(irclt_pkg::KIND_TRAIL, c, 1'b1, 1'b0, 1'b0);
            end
            irclt_pkg::MODE_BAD: begin
                o.valid = 1'b0;
            end
            default: begin
                o.valid = (c != irclt_pkg::CH_SPACE) && (c != irclt_pkg::CH_COLON);
                o.res   = mk(irclt_pkg::KIND_COMMAND, upcase(c), 1'b1, 1'b1, 1'b0);
            end
        endcase
        return o;
    endfunction

    // The first of the two possible end-of-line results: an empty token start or
    // the end item itself.
    function automatic cand_t lf_first(input irclt_pkg::mode_t mode);
        cand_t o;
        o.valid = 1'b1;
        o.res   = mk(irclt_pkg::KIND_END, 8'h00, 1'b0, 1'b0, 1'b0);
        unique case (mode)
            irclt_pkg::MODE_PREFIX_FIRST, irclt_pkg::MODE_PREFIX, irclt_pkg::MODE_BAD:
                o.res = mk(irclt_pkg::KIND_END, 8'h00, 1'b0, 1'b0, 1'b1);
            irclt_pkg::MODE_PRE_CMD:
                o.res = mk(irclt_pkg::KIND_COMMAND, 8'h00, 1'b0, 1'b1, 1'b0);
            irclt_pkg::MODE_TRAIL_FIRST:
                o.res = mk(irclt_pkg::KIND_TRAIL, 8'h00, 1'b0, 1'b1, 1'b0);
            irclt_pkg::MODE_CMD, irclt_pkg::MODE_PRE_PARAM, irclt_pkg::MODE_MIDDLE,
            irclt_pkg::MODE_TRAIL:
                o.valid = 1'b1;
            default:
                o.valid = 1'b0;
        endcase
        return o;
    endfunction

    function automatic cand_t lf_second(input irclt_pkg::mode_t mode);
        cand_t o;
        o.valid = (mode == irclt_pkg::MODE_PRE_CMD) || (mode == irclt_pkg::MODE_TRAIL_FIRST);
        o.res   = mk(irclt_pkg::KIND_END, 8'h00, 1'b0, 1'b0, 1'b0);
        return o;
    endfunction

    irclt_pkg::mode_t mode_reg, mode_next, mode_mid;
    logic             pending_cr_reg, pending_cr_next;

    result_t          queue_mem [QUEUE_DEPTH];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       count_reg;

    logic             in_xfer, out_xfer;
    logic             lf_after_cr, is_cr, is_lf;
    cand_t            cand [3];
    result_t          res0, res1;
    logic [1:0]       n_res;

    assign in_xfer     = s_tvalid && s_tready;
    assign out_xfer    = m_tvalid && m_tready;
    assign is_cr       = (s_tdata == irclt_pkg::CH_CR);
    assign is_lf       = (s_tdata == irclt_pkg::CH_LF);
    assign lf_after_cr = pending_cr_reg && is_lf;

    // Next parse state.
    always_comb begin
        mode_mid        = (pending_cr_reg && !is_lf) ? byte_next(mode_reg, irclt_pkg::CH_CR)
                                                     : mode_reg;
        mode_next       = mode_mid;
        pending_cr_next = 1'b0;
        if (lf_after_cr || is_lf) begin
            mode_next = irclt_pkg::MODE_LINE_START;
        end else if (is_cr) begin
            pending_cr_next = 1'b1;
        end else begin
            mode_next = byte_next(mode_mid, s_tdata);
        end
    end

    // Results of this byte, compacted to at most two items.
    always_comb begin
        cand[0] = byte_out(mode_reg, irclt_pkg::CH_CR);
        cand[1] = byte_out(mode_mid, s_tdata);
        cand[2] = lf_second(mode_mid);
        if (!pending_cr_reg || lf_after_cr) begin
            cand[0].valid = 1'b0;
        end
        if (is_lf) begin
            cand[1] = lf_first(mode_mid);
        end else begin
            cand[2].valid = 1'b0;
        end
        if (is_cr) begin
            cand[1].valid = 1'b0;
        end

        res0  = cand[0].valid ? cand[0].res : cand[1].res;
        res1  = cand[0].valid ? cand[1].res : cand[2].res;
        n_res = 2'(cand[0].valid) + 2'(cand[1].valid) + 2'(cand[2].valid);
        if (n_res == 2'd1) begin
            res0.last = 1'b1;
        end
        res1.last = 1'b1;
    end

    assign s_tready = (count_reg <= 3'(QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = queue_mem[rd_ptr_reg].data;
    assign m_tuser  = {queue_mem[rd_ptr_reg].malformed, queue_mem[rd_ptr_reg].start,
                       queue_mem[rd_ptr_reg].has_byte, queue_mem[rd_ptr_reg].kind};
    assign m_tlast  = queue_mem[rd_ptr_reg].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= irclt_pkg::MODE_LINE_START;
            pending_cr_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (in_xfer) begin
                mode_reg       <= mode_next;
                pending_cr_reg <= pending_cr_next;
                wr_ptr_reg     <= wr_ptr_reg + n_res;
            end
            if (out_xfer) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (in_xfer ? 3'(n_res) : 3'd0) - 3'(out_xfer);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && n_res != 2'd0) begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (in_xfer && n_res == 2'd2) begin
            queue_mem[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QUEUE_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_cr_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && is_cr) |=> pending_cr_reg)
        else $error("An accepted CR was not held back.");

    a_end_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] == irclt_pkg::KIND_END) |-> (!m_tuser[3] && m_tlast))
        else $error("End item carries a byte or is not the last result of its byte.");

    a_malformed_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[5]) |-> (m_tuser[2:0] == irclt_pkg::KIND_END))
        else $error("Malformed flag set on an item that is not an end item.");

endmodule
